[design/olist_pkg.sv]
// Package for the ordered list engine: field widths, codes and the cell control bundle.
// Used by olist_cell, olist_reduce, ordered_list_engine and tb_top; depends on nothing else.

package olist_pkg;

    // Default sizing
    localparam int DEFAULT_DEPTH      = 64;
    localparam int DEFAULT_ELEM_WIDTH = 32;

    // Fixed field widths on the stream ports
    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int POSB_W  = 6;
    localparam int VALUE_W = 32;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 6;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    // Packed stream widths, rounded up to whole bytes
    localparam int IN_FIELDS_W  = POS_W + POSB_W + VALUE_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = DATA_W + INDEX_W + STAT_W + COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Cells per reduction group and local index width
    localparam int GSIZE  = 8;
    localparam int GIDX_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_ERASE  = 3'd3,
        CMD_READ   = 3'd4,
        CMD_FIND   = 3'd5,
        CMD_SWAP   = 3'd6,
        CMD_CLEAR  = 3'd7
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Operation broadcast to every cell
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_SCAN,
        OP_PUSH,
        OP_INSERT,
        OP_ERASE,
        OP_SWAP
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        logic [POS_W-1:0]  pa;
        logic [POSB_W-1:0] pb;
    } cell_ctl_t;

endpackage

[design/olist_cell.sv]
// One storage cell of the ordered list: holds a single entry and trades it with its neighbours.
// Depends on olist_pkg.

module olist_cell #(
    parameter int DEPTH      = olist_pkg::DEFAULT_DEPTH,
    parameter int ELEM_WIDTH = olist_pkg::DEFAULT_ELEM_WIDTH,
    parameter int IDX        = 0
) (
    input  logic                         clk,
    input  olist_pkg::cell_ctl_t         ctl,
    input  logic [$clog2(DEPTH+1)-1:0]   count,
    input  logic [ELEM_WIDTH-1:0]        value,
    input  logic [ELEM_WIDTH-1:0]        swap_a,
    input  logic [ELEM_WIDTH-1:0]        swap_b,
    input  logic [ELEM_WIDTH-1:0]        left,
    input  logic [ELEM_WIDTH-1:0]        right,
    output logic [ELEM_WIDTH-1:0]        entry,
    output logic                         match,
    output logic [ELEM_WIDTH-1:0]        sel_a,
    output logic [ELEM_WIDTH-1:0]        sel_b
);
    import olist_pkg::*;

    localparam int CNTW = $clog2(DEPTH + 1);
    localparam int CMPW = (CNTW > POS_W) ? CNTW : POS_W;

    logic [ELEM_WIDTH-1:0] entry_reg;
    logic [ELEM_WIDTH-1:0] entry_next;
    logic                  match_reg;
    logic [ELEM_WIDTH-1:0] sel_a_reg;
    logic [ELEM_WIDTH-1:0] sel_b_reg;
    logic                  at_pa;
    logic                  above_pa;
    logic                  at_pb;
    logic                  at_count;
    logic                  valid_here;

    // Where this cell sits relative to the broadcast positions
    assign at_pa      = CMPW'(IDX) == CMPW'(ctl.pa);
    assign above_pa   = CMPW'(IDX) >  CMPW'(ctl.pa);
    assign at_pb      = CMPW'(IDX) == CMPW'(ctl.pb);
    assign at_count   = CNTW'(IDX) == count;
    assign valid_here = CNTW'(IDX) <  count;

    // Next entry value
    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            OP_PUSH:
            begin
                if (at_count)
                    entry_next = value;
            end
            OP_INSERT:
            begin
                if (at_pa)
                    entry_next = value;
                else if (above_pa)
                    entry_next = left;
            end
            OP_ERASE:
            begin
                if (at_pa || above_pa)
                    entry_next = right;
            end
            OP_SWAP:
            begin
                if (at_pa)
                    entry_next = swap_b;
                else if (at_pb)
                    entry_next = swap_a;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Entry storage and scan results
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (ctl.op == OP_SCAN)
        begin
            match_reg <= valid_here && (entry_reg == value);
            sel_a_reg <= at_pa ? entry_reg : '0;
            sel_b_reg <= at_pb ? entry_reg : '0;
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;
    assign sel_a = sel_a_reg;
    assign sel_b = sel_b_reg;

endmodule

[design/olist_reduce.sv]
// Registered reduction over one group of cells: first match and the two selected entries.
// Depends on olist_pkg.

module olist_reduce #(
    parameter int ELEM_WIDTH = olist_pkg::DEFAULT_ELEM_WIDTH
) (
    input  logic                                          clk,
    input  logic                                          en,
    input  logic [olist_pkg::GSIZE-1:0]                   match,
    input  logic [olist_pkg::GSIZE-1:0][ELEM_WIDTH-1:0]   a_in,
    input  logic [olist_pkg::GSIZE-1:0][ELEM_WIDTH-1:0]   b_in,
    output logic                                          any,
    output logic [olist_pkg::GIDX_W-1:0]                  idx,
    output logic [ELEM_WIDTH-1:0]                         a_out,
    output logic [ELEM_WIDTH-1:0]                         b_out
);
    import olist_pkg::*;

    logic                  any_reg;
    logic [GIDX_W-1:0]     idx_reg;
    logic [ELEM_WIDTH-1:0] a_reg;
    logic [ELEM_WIDTH-1:0] b_reg;
    logic [GIDX_W-1:0]     idx_c;
    logic [ELEM_WIDTH-1:0] a_c;
    logic [ELEM_WIDTH-1:0] b_c;

    // Lowest matching cell wins; selected entries are one-hot so OR them
    always_comb
    begin
        idx_c = '0;
        a_c   = '0;
        b_c   = '0;
        for (int i = GSIZE - 1; i >= 0; i--)
        begin
            if (match[i])
                idx_c = GIDX_W'(i);
            a_c = a_c | a_in[i];
            b_c = b_c | b_in[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            any_reg <= |match;
            idx_reg <= idx_c;
            a_reg   <= a_c;
            b_reg   <= b_c;
        end
    end

    assign any   = any_reg;
    assign idx   = idx_reg;
    assign a_out = a_reg;
    assign b_out = b_reg;

endmodule

[design/ordered_list_engine.sv]
// Ordered list engine top level: request sequencer, cell chain and group reduction.
// Depends on olist_pkg, olist_cell and olist_reduce.

// A request is latched at its accepting edge. Every cell then compares and selects in
// parallel (S_SCAN), the per-group reduction is registered (S_GROUP), and the first
// match is resolved while the cell chain shifts, pushes or swaps (S_EXEC); the result
// register then holds until taken. A new request is accepted in the cycle after the
// previous result has gone, so requests never overlap and any output stall delays the
// next one. Insert and erase move every later entry by one cell at the same edge.
// The entry store needs no clearing after reset: only entries below the count are read.

module ordered_list_engine #(
    parameter int DEPTH      = olist_pkg::DEFAULT_DEPTH,
    parameter int ELEM_WIDTH = olist_pkg::DEFAULT_ELEM_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [6:0] position, [12:7] position_b, [44:13] value, [47:45] zero
    input  logic [olist_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] command
    input  logic [olist_pkg::CMD_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] data_out, [37:32] index_out, [39:38] status, [46:40] count, [47] zero
    output logic [olist_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import olist_pkg::*;

    localparam int CNTW    = $clog2(DEPTH + 1);
    localparam int CMPW    = (CNTW > POS_W) ? CNTW : POS_W;
    localparam int IW      = $clog2(DEPTH);
    localparam int NGROUPS = (DEPTH + GSIZE - 1) / GSIZE;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GROUP,
        S_EXEC,
        S_OUT
    } state_t;

    state_t              state_reg;
    logic [CNTW-1:0]     count_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   data_out_reg;
    logic [INDEX_W-1:0]  index_out_reg;
    status_t             status_reg;
    logic [COUNT_W-1:0]  count_out_reg;

    cmd_t                  cmd_reg;
    logic [POS_W-1:0]      pa_reg;
    logic [POSB_W-1:0]     pb_reg;
    logic [ELEM_WIDTH-1:0] value_reg;

    logic                  in_req;
    logic                  out_req;

    // Execute-stage results
    status_t               st_c;
    logic [ELEM_WIDTH-1:0] data_c;
    logic [IW-1:0]         idx_c;
    logic [CNTW-1:0]       count_next;
    cell_op_t              exec_op;
    logic                  found_c;
    logic [IW-1:0]         found_idx_c;
    logic [ELEM_WIDTH-1:0] val_a_c;
    logic [ELEM_WIDTH-1:0] val_b_c;
    logic                  full_c;
    logic                  pa_ge_cnt;
    logic                  pa_gt_cnt;
    logic                  pb_ge_cnt;

    cell_ctl_t             ctl;

    // Cell chain wiring
    logic [ELEM_WIDTH-1:0] cell_entry [DEPTH];
    logic                  cell_match [DEPTH];
    logic [ELEM_WIDTH-1:0] cell_a     [DEPTH];
    logic [ELEM_WIDTH-1:0] cell_b     [DEPTH];

    // Group reduction wiring
    logic [GSIZE-1:0]                  grp_match_in [NGROUPS];
    logic [GSIZE-1:0][ELEM_WIDTH-1:0]  grp_a_in     [NGROUPS];
    logic [GSIZE-1:0][ELEM_WIDTH-1:0]  grp_b_in     [NGROUPS];
    logic                              grp_any      [NGROUPS];
    logic [GIDX_W-1:0]                 grp_idx      [NGROUPS];
    logic [ELEM_WIDTH-1:0]             grp_a        [NGROUPS];
    logic [ELEM_WIDTH-1:0]             grp_b        [NGROUPS];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign out_req       = m_axis_tvalid && m_axis_tready;

    // Request latch
    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            cmd_reg   <= cmd_t'(s_axis_tuser);
            pa_reg    <= s_axis_tdata[POS_W-1:0];
            pb_reg    <= s_axis_tdata[POS_W+POSB_W-1:POS_W];
            value_reg <= ELEM_WIDTH'(s_axis_tdata[POS_W+POSB_W+VALUE_W-1:POS_W+POSB_W]);
        end
    end

    // Broadcast to the cells
    always_comb
    begin
        ctl.pa = pa_reg;
        ctl.pb = pb_reg;
        case (state_reg)
            S_SCAN:  ctl.op = OP_SCAN;
            S_EXEC:  ctl.op = exec_op;
            default: ctl.op = OP_IDLE;
        endcase
    end

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ELEM_WIDTH-1:0] left_w;
        logic [ELEM_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_w = cell_entry[i];
        end
        else
        begin : g_mid_r
            assign right_w = cell_entry[i+1];
        end

        olist_cell #(
            .DEPTH      (DEPTH),
            .ELEM_WIDTH (ELEM_WIDTH),
            .IDX        (i)
        ) u_cell (
            .clk    (clk),
            .ctl    (ctl),
            .count  (count_reg),
            .value  (value_reg),
            .swap_a (val_a_c),
            .swap_b (val_b_c),
            .left   (left_w),
            .right  (right_w),
            .entry  (cell_entry[i]),
            .match  (cell_match[i]),
            .sel_a  (cell_a[i]),
            .sel_b  (cell_b[i])
        );
    end

    // Per-group reduction
    for (genvar g = 0; g < NGROUPS; g++)
    begin : g_group
        for (genvar k = 0; k < GSIZE; k++)
        begin : g_slot
            if (g * GSIZE + k < DEPTH)
            begin : g_used
                assign grp_match_in[g][k] = cell_match[g*GSIZE+k];
                assign grp_a_in[g][k]     = cell_a[g*GSIZE+k];
                assign grp_b_in[g][k]     = cell_b[g*GSIZE+k];
            end
            else
            begin : g_pad
                assign grp_match_in[g][k] = 1'b0;
                assign grp_a_in[g][k]     = '0;
                assign grp_b_in[g][k]     = '0;
            end
        end

        olist_reduce #(
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_reduce (
            .clk   (clk),
            .en    (state_reg == S_GROUP),
            .match (grp_match_in[g]),
            .a_in  (grp_a_in[g]),
            .b_in  (grp_b_in[g]),
            .any   (grp_any[g]),
            .idx   (grp_idx[g]),
            .a_out (grp_a[g]),
            .b_out (grp_b[g])
        );
    end

    // Combine groups: first matching group, selected entries
    always_comb
    begin
        found_c     = 1'b0;
        found_idx_c = '0;
        val_a_c     = '0;
        val_b_c     = '0;
        for (int g = NGROUPS - 1; g >= 0; g--)
        begin
            if (grp_any[g])
            begin
                found_c     = 1'b1;
                found_idx_c = IW'(g * GSIZE + int'(grp_idx[g]));
            end
            val_a_c = val_a_c | grp_a[g];
            val_b_c = val_b_c | grp_b[g];
        end
    end

    // Range and capacity checks
    assign full_c    = (count_reg == CNTW'(DEPTH));
    assign pa_ge_cnt = CMPW'(pa_reg) >= CMPW'(count_reg);
    assign pa_gt_cnt = CMPW'(pa_reg) >  CMPW'(count_reg);
    assign pb_ge_cnt = CMPW'(pb_reg) >= CMPW'(count_reg);

    // Command decode for the execute step
    always_comb
    begin
        st_c       = ST_OK;
        data_c     = '0;
        idx_c      = '0;
        count_next = count_reg;
        exec_op    = OP_IDLE;
        case (cmd_reg)
            CMD_PUSH:
            begin
                if (full_c)
                    st_c = ST_FULL;
                else
                begin
                    exec_op    = OP_PUSH;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP:
            begin
                if (count_reg == '0)
                    st_c = ST_RANGE;
                else
                    count_next = count_reg - 1'b1;
            end
            CMD_INSERT:
            begin
                if (pa_gt_cnt)
                    st_c = ST_RANGE;
                else if (full_c)
                    st_c = ST_FULL;
                else
                begin
                    exec_op    = OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_ERASE:
            begin
                if (pa_ge_cnt)
                    st_c = ST_RANGE;
                else
                begin
                    exec_op    = OP_ERASE;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_READ:
            begin
                if (pa_ge_cnt)
                    st_c = ST_RANGE;
                else
                    data_c = val_a_c;
            end
            CMD_FIND:
            begin
                if (found_c)
                    idx_c = found_idx_c;
                else
                    st_c = ST_NOTFOUND;
            end
            CMD_SWAP:
            begin
                if (pa_ge_cnt || pb_ge_cnt)
                    st_c = ST_RANGE;
                else
                    exec_op = OP_SWAP;
            end
            CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                st_c = ST_OK;
            end
        endcase
    end

    // Sequencer, count and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            data_out_reg  <= '0;
            index_out_reg <= '0;
            status_reg    <= ST_OK;
            count_out_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_req)
                        state_reg <= S_SCAN;
                end
                S_SCAN:
                begin
                    state_reg <= S_GROUP;
                end
                S_GROUP:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    count_reg     <= count_next;
                    data_out_reg  <= DATA_W'(data_c);
                    index_out_reg <= INDEX_W'(idx_c);
                    status_reg    <= st_c;
                    count_out_reg <= COUNT_W'(count_next);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_req)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({count_out_reg, status_reg, index_out_reg, data_out_reg});

    // Count never passes capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(DEPTH))
        else $error("entry count above capacity");

    // One request in flight: no acceptance while a result waits
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("request accepted while result pending");

    // The count only moves on the execute step
    a_count_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(state_reg == S_EXEC))
        else $error("count changed outside execute step");

    // Delivered result frees the input side next cycle
    a_ready_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_req |=> s_axis_tready && !m_axis_tvalid)
        else $error("engine not idle after result delivered");

endmodule

[tb/tb_top.sv]
// Testbench for ordered_list_engine: a directed table, then random command streams,
// each result checked against its typed table row or an in-bench model of the bounded ordered list.
// Depends on olist_pkg and ordered_list_engine.

module tb_top;

    import olist_pkg::*;

    localparam int LIST_DEPTH     = DEFAULT_DEPTH;
    localparam int RANDOM_ITEMS   = 880;
    localparam int QUIET_ITEMS    = 150;
    localparam int LONG_HOLD      = 64;
    localparam int HOLD_AT        = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIX
    } fill_mode_t;

    // Command weights in percent, by code: push, pop, insert, erase, read, find, swap, clear
    localparam int CMD_WEIGHT [3][8] = '{
        '{50,  2, 35,  2,  4,  4,  3, 0},
        '{10, 30,  8, 30,  8,  6,  6, 2},
        '{15, 10, 15, 12, 15, 15, 15, 3}
    };

    typedef struct packed {
        logic [DATA_W-1:0]  data;
        logic [INDEX_W-1:0] index;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } list_result_t;

    typedef struct {
        cmd_t                cmd;
        logic [POS_W-1:0]    pos;
        logic [POSB_W-1:0]   pos_b;
        logic [VALUE_W-1:0]  value;
        logic                typed;
        list_result_t        want;
    } list_request_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Model of the list, advanced once per accepted request
    logic [DATA_W-1:0] list_store [LIST_DEPTH];
    int                list_len = 0;

    list_result_t pending_results [$];
    int           mismatch_count = 0;
    int           results_taken = 0;
    int           quiet_cycles = 0;
    logic         quiet_phase = 1'b0;

    // Directed rows; typed expectations where they follow at a glance
    list_request_t directed_rows [25] = '{
        '{CMD_POP,    7'd0,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_RANGE,    7'd0}},
        '{CMD_READ,   7'd0,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_RANGE,    7'd0}},
        '{CMD_ERASE,  7'd0,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_RANGE,    7'd0}},
        '{CMD_SWAP,   7'd0,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_RANGE,    7'd0}},
        '{CMD_FIND,   7'd0,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_NOTFOUND, 7'd0}},
        '{CMD_INSERT, 7'd1,  6'd0,  32'h0000_0005, 1'b1, '{32'h0, 6'd0, ST_RANGE,    7'd0}},
        '{CMD_INSERT, 7'd0,  6'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0, 6'd0, ST_OK,       7'd1}},
        '{CMD_PUSH,   7'd0,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_OK,       7'd2}},
        '{CMD_READ,   7'd0,  6'd0,  32'h0000_0000, 1'b1, '{32'hFFFF_FFFF, 6'd0, ST_OK, 7'd2}},
        '{CMD_READ,   7'd1,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_OK,       7'd2}},
        '{CMD_FIND,   7'd0,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 6'd1, ST_OK,       7'd2}},
        '{CMD_PUSH,   7'd0,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_OK,       7'd3}},
        '{CMD_FIND,   7'd0,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 6'd1, ST_OK,       7'd3}},
        '{CMD_SWAP,   7'd0,  6'd2,  32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_OK,       7'd3}},
        '{CMD_FIND,   7'd0,  6'd0,  32'hFFFF_FFFF, 1'b1, '{32'h0, 6'd2, ST_OK,       7'd3}},
        '{CMD_SWAP,   7'd1,  6'd1,  32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_OK,       7'd3}},
        '{CMD_READ,   7'd64, 6'd0,  32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_RANGE,    7'd3}},
        '{CMD_INSERT, 7'd64, 6'd0,  32'h1234_5678, 1'b1, '{32'h0, 6'd0, ST_RANGE,    7'd3}},
        '{CMD_INSERT, 7'd1,  6'd0,  32'hA5A5_A5A5, 1'b0, '0},
        '{CMD_ERASE,  7'd0,  6'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_SWAP,   7'd0,  6'd63, 32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_RANGE,    7'd3}},
        '{CMD_READ,   7'd2,  6'd0,  32'h0000_0000, 1'b0, '0},
        '{CMD_CLEAR,  7'd5,  6'd9,  32'h5A5A_5A5A, 1'b1, '{32'h0, 6'd0, ST_OK,       7'd0}},
        '{CMD_POP,    7'd0,  6'd0,  32'h0000_0000, 1'b1, '{32'h0, 6'd0, ST_RANGE,    7'd0}},
        '{CMD_PUSH,   7'd0,  6'd0,  32'h8000_0001, 1'b1, '{32'h0, 6'd0, ST_OK,       7'd1}}
    };

    ordered_list_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the list model and returns the result it yields
    function automatic list_result_t apply_list_command(cmd_t cmd, logic [POS_W-1:0] pos,
                                                        logic [POSB_W-1:0] pos_b,
                                                        logic [VALUE_W-1:0] key);
        list_result_t     r;
        logic [DATA_W-1:0] held;
        int               i;
        r        = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_PUSH:
                if (list_len >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    list_store[list_len] = key;
                    list_len++;
                end
            CMD_POP:
                if (list_len == 0)
                    r.status = ST_RANGE;
                else
                    list_len--;
            CMD_INSERT:
                // range check wins over the full check
                if (int'(pos) > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > int'(pos); i--)
                        list_store[i] = list_store[i-1];
                    list_store[pos] = key;
                    list_len++;
                end
            CMD_ERASE:
                if (int'(pos) >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = int'(pos); i + 1 < list_len; i++)
                        list_store[i] = list_store[i+1];
                    list_len--;
                end
            CMD_READ:
                if (int'(pos) >= list_len)
                    r.status = ST_RANGE;
                else
                    r.data = list_store[pos];
            CMD_FIND:
            begin
                r.status = ST_NOTFOUND;
                for (i = 0; i < list_len; i++)
                begin
                    if (list_store[i] == key)
                    begin
                        r.index  = INDEX_W'(i);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            CMD_SWAP:
                if (int'(pos) >= list_len || int'(pos_b) >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    held              = list_store[pos];
                    list_store[pos]   = list_store[pos_b];
                    list_store[pos_b] = held;
                end
            default:
                list_len = 0;
        endcase
        r.count = COUNT_W'(list_len);
        return r;
    endfunction

    // Random request shaped by the current fill mode and the model's length
    function automatic list_request_t pick_random_request(fill_mode_t mode);
        list_request_t rq;
        int            roll;
        int            acc;
        int            c;
        roll   = $urandom_range(0, 99);
        acc    = 0;
        rq.cmd = CMD_CLEAR;
        for (c = 0; c < 8; c++)
        begin
            acc += CMD_WEIGHT[mode][c];
            if (roll < acc)
            begin
                rq.cmd = cmd_t'(c);
                break;
            end
        end
        // mostly in-range positions, some anywhere up to the capacity
        if ($urandom_range(0, 4) == 0)
            rq.pos = POS_W'($urandom_range(0, LIST_DEPTH));
        else
            rq.pos = POS_W'($urandom_range(0, list_len));
        if ($urandom_range(0, 4) == 0 || list_len == 0)
            rq.pos_b = POSB_W'($urandom_range(0, LIST_DEPTH - 1));
        else
            rq.pos_b = POSB_W'($urandom_range(0, list_len - 1));
        // small values now and then so that duplicates turn up
        if ($urandom_range(0, 3) == 0)
            rq.value = VALUE_W'($urandom_range(0, 3));
        else
            rq.value = $urandom;
        if (rq.cmd == CMD_FIND && list_len > 0 && $urandom_range(0, 1) == 0)
            rq.value = list_store[$urandom_range(0, list_len - 1)];
        rq.typed = 1'b0;
        rq.want  = '0;
        return rq;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got_v, longint unsigned want_v);
        $display("mismatch on result %0d: %s got 0x%0h, want 0x%0h",
                 results_taken, what, got_v, want_v);
        mismatch_count++;
    endtask

    // Offers one request, waits for the handshake, then records its expected result
    task automatic offer_request(list_request_t rq);
        list_result_t predicted;
        if (!quiet_phase && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.cmd;
        s_axis_tdata  <= {3'b000, rq.value, rq.pos_b, rq.pos};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = apply_list_command(rq.cmd, rq.pos, rq.pos_b, rq.value);
        pending_results.push_back(rq.typed ? rq.want : predicted);
    endtask

    // Result side: short random stalls, one long hold to back the engine up
    initial
    begin : result_ready
        int stall_left;
        bit hold_done;
        stall_left = 0;
        hold_done  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (!hold_done && results_taken >= HOLD_AT)
            begin
                stall_left = LONG_HOLD;
                hold_done  = 1'b1;
            end
            else if (!quiet_phase && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 4);
            m_axis_tready <= (stall_left == 0);
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        list_result_t got;
        list_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.data   = m_axis_tdata[31:0];
            got.index  = m_axis_tdata[37:32];
            got.status = status_t'(m_axis_tdata[39:38]);
            got.count  = m_axis_tdata[46:40];
            results_taken++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, tdata", m_axis_tdata, 0);
            else
            begin
                want = pending_results.pop_front();
                if (got.data !== want.data)
                    report_mismatch("data_out", got.data, want.data);
                if (got.index !== want.index)
                    report_mismatch("index_out", got.index, want.index);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.count !== want.count)
                    report_mismatch("count", got.count, want.count);
            end
        end
    end

    // Watchdog on cycles with no request or result taken
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ordered_list_engine test failed");
            $finish;
        end
    end

    // Reset, directed table, random streams, drain and verdict
    initial
    begin : stimulus
        fill_mode_t mode;
        int         block_left;
        int         n;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
            offer_request(directed_rows[k]);

        // first block grows the list so that it reaches full early on
        mode       = MODE_GROW;
        block_left = 120;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (block_left == 0)
            begin
                mode       = fill_mode_t'($urandom_range(0, 2));
                block_left = $urandom_range(80, 160);
            end
            block_left--;
            if (n >= RANDOM_ITEMS - QUIET_ITEMS)
                quiet_phase = 1'b1;
            offer_request(pick_random_request(mode));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("ordered_list_engine test passed");
        else
            $display("ordered_list_engine test failed");
        $finish;
    end

endmodule

[sim.f]
design/olist_pkg.sv
design/olist_cell.sv
design/olist_reduce.sv
design/ordered_list_engine.sv
tb/tb_top.sv
